>>> hw/rtl/gfsf_pkg.sv
// shared types and constants for the gravity follow smoothing filter
package gfsf_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned BtnW  = 5;
  localparam int unsigned PresW = 17;
  localparam int unsigned GainW = 24;
  localparam int unsigned PGainW = 25;
  localparam int unsigned DtW   = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 25;

  localparam logic [1:0] RELEASE_TICKS = 2'd2;

  localparam logic [GainW-1:0] GainReset = 24'd655360;
  localparam logic [DtW-1:0]   TickReset = 24'd33554;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRAVITY    = 3'd0,
    CFG_FRICTION   = 3'd1,
    CFG_P_GRAVITY  = 3'd2,
    CFG_P_FRICTION = 3'd3,
    CFG_TICK       = 3'd4
  } cfg_idx_e;

endpackage

>>> hw/rtl/gfsf_in_if.sv
// input channel carrying one pen sample item
interface gfsf_in_if import gfsf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PosW-1:0]  target_x;
  logic signed [PosW-1:0]  target_y;
  logic [BtnW-1:0]         button_bits;
  logic [PresW-1:0]        pen_pressure;

  modport source (output valid, target_x, target_y, button_bits, pen_pressure, input ready);
  modport sink   (input valid, target_x, target_y, button_bits, pen_pressure, output ready);
endinterface

>>> hw/rtl/gfsf_out_if.sv
// output channel carrying one filtered position item
interface gfsf_out_if import gfsf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PosW-1:0]  out_x;
  logic signed [PosW-1:0]  out_y;
  logic [BtnW-1:0]         out_buttons;
  logic [PresW-1:0]        out_pressure;

  modport source (output valid, out_x, out_y, out_buttons, out_pressure, input ready);
  modport sink   (input valid, out_x, out_y, out_buttons, out_pressure, output ready);
endinterface

>>> hw/rtl/gravity_follow_smoothing_filter.sv
// gravity follow smoothing filter top level: sequencer around one multiplier, sqrt and divider
// each item runs three bit serial square roots and two bit serial divisions with pull and
// friction, no divisions when the distance is zero, and skips the friction steps when the speed check fails
// items are taken one at a time: a new item is accepted only once the last one is through
// the result sits in an output register, so the next item is taken while it waits
// reset: async active low, clears position, velocity, hold counter and loads default gains
module gravity_follow_smoothing_filter import gfsf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  gfsf_in_if.sink             in_i,
  gfsf_out_if.source          out_o
);

  typedef enum logic [5:0] {
    S_IDLE, S_DIFF, S_GEG, S_KG1, S_MAGB, S_SUMD, S_SQD, S_SLOAD, S_SQS,
    S_MULX, S_DLX, S_DIVX, S_ADDX, S_MULY, S_DLY, S_DIVY, S_ADDY,
    S_VMA, S_VMB, S_SUMV, S_SQV, S_FCHK, S_PF, S_GEF, S_KF1, S_KF2,
    S_FX, S_FY, S_FYW, S_MX, S_MY, S_MYW, S_DONE
  } state_e;

  localparam logic [5:0] SqrtLast = 6'd31;
  localparam logic [5:0] DivLast  = 6'd59;

  function automatic logic signed [65:0] tz_shift(input logic signed [65:0] x,
                                                 input int unsigned k);
    logic signed [65:0] b;
    b = x[65] ? ((66'sd1 <<< k) - 66'sd1) : 66'sd0;
    return (x + b) >>> k;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (x < -66'sd2147483648) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  state_e state_q;

  logic [GainW-1:0]         grav_q, fric_q;
  logic signed [PGainW-1:0] pgrav_q, pfric_q;
  logic [DtW-1:0]           dt_q;

  logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
  logic [1:0]         hold_q;

  logic signed [31:0] tx_q, ty_q;
  logic [BtnW-1:0]    btn_q;
  logic [PresW-1:0]   pres_q;

  logic signed [32:0] dx_q, dy_q;
  logic signed [27:0] ge_q, kg_q;
  logic               sh_q;
  logic [63:0]        acc_q, rad_q;
  logic [31:0]        root_q;
  logic [34:0]        rem_q;
  logic [24:0]        s_q;
  logic [59:0]        num_q;
  logic [24:0]        drem_q;
  logic               neg_q;
  logic [5:0]         cnt_q;

  logic                 out_valid_q;
  logic signed [31:0]   ox_q, oy_q;
  logic [BtnW-1:0]      obtn_q;
  logic [PresW-1:0]     opres_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;

  // magnitude operands
  logic signed [32:0] mag_a, mag_b;
  logic [32:0]        ua, ub;
  logic               halve;
  logic signed [32:0] ua_op, ub_op;

  always_comb begin
    if (state_q == S_VMA || state_q == S_VMB) begin
      mag_a = 33'(vel_x_q);
      mag_b = 33'(vel_y_q);
    end else begin
      mag_a = dx_q;
      mag_b = dy_q;
    end
    ua = mag_a[32] ? 33'(-mag_a) : 33'(mag_a);
    ub = mag_b[32] ? 33'(-mag_b) : 33'(mag_b);
    halve = (ua >= 33'h0_8000_0000) || (ub >= 33'h0_8000_0000);
    ua_op = halve ? $signed(ua >> 1) : $signed(ua);
    ub_op = halve ? $signed(ub >> 1) : $signed(ub);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_DIFF: begin
        mul_a = $signed({16'd0, pres_q});
        mul_b = 33'(pgrav_q);
      end
      S_PF: begin
        mul_a = $signed({16'd0, pres_q});
        mul_b = 33'(pfric_q);
      end
      S_GEG, S_VMA: begin
        mul_a = ua_op;
        mul_b = ua_op;
      end
      S_MAGB, S_VMB: begin
        mul_a = ub_op;
        mul_b = ub_op;
      end
      S_KG1, S_KF1: begin
        mul_a = 33'(ge_q);
        mul_b = $signed({9'd0, dt_q});
      end
      S_MULX: begin
        mul_a = dx_q;
        mul_b = 33'(kg_q);
      end
      S_MULY: begin
        mul_a = dy_q;
        mul_b = 33'(kg_q);
      end
      S_FX, S_MX: begin
        mul_a = 33'(vel_x_q);
        mul_b = (state_q == S_FX) ? 33'(kg_q) : $signed({9'd0, dt_q});
      end
      S_FY, S_MY: begin
        mul_a = 33'(vel_y_q);
        mul_b = (state_q == S_FY) ? 33'(kg_q) : $signed({9'd0, dt_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // sqrt and divider steps
  logic [36:0] sq_rem_t, sq_trial;
  logic        sq_ge;
  logic [25:0] dv_rem_t;
  logic        dv_ge;
  logic [32:0] root_sh;
  logic signed [65:0] q_s, prod_abs;

  always_comb begin
    sq_rem_t = {rem_q, rad_q[63:62]};
    sq_trial = {3'd0, root_q, 2'b01};
    sq_ge    = sq_rem_t >= sq_trial;
    dv_rem_t = {drem_q, num_q[59]};
    dv_ge    = dv_rem_t >= {1'b0, s_q};
    root_sh  = sh_q ? {root_q, 1'b0} : {1'b0, root_q};
    q_s      = neg_q ? -$signed({6'd0, num_q}) : $signed({6'd0, num_q});
    prod_abs = prod_q[65] ? -prod_q : prod_q;
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.out_x        = ox_q;
  assign out_o.out_y        = oy_q;
  assign out_o.out_buttons  = obtn_q;
  assign out_o.out_pressure = opres_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      grav_q  <= GainReset;
      fric_q  <= GainReset;
      pgrav_q <= '0;
      pfric_q <= '0;
      dt_q    <= TickReset;
      pos_x_q <= '0;
      pos_y_q <= '0;
      vel_x_q <= '0;
      vel_y_q <= '0;
      hold_q  <= '0;
      tx_q <= '0; ty_q <= '0; btn_q <= '0; pres_q <= '0;
      dx_q <= '0; dy_q <= '0; ge_q <= '0; kg_q <= '0; sh_q <= 1'b0;
      acc_q <= '0; rad_q <= '0; root_q <= '0; rem_q <= '0; s_q <= '0;
      num_q <= '0; drem_q <= '0; neg_q <= 1'b0; cnt_q <= '0;
      out_valid_q <= 1'b0;
      ox_q <= '0; oy_q <= '0; obtn_q <= '0; opres_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GRAVITY:    grav_q  <= cfg_data_i[GainW-1:0];
          CFG_FRICTION:   fric_q  <= cfg_data_i[GainW-1:0];
          CFG_P_GRAVITY:  pgrav_q <= $signed(cfg_data_i);
          CFG_P_FRICTION: pfric_q <= $signed(cfg_data_i);
          CFG_TICK:       dt_q    <= cfg_data_i[DtW-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && out_o.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            tx_q   <= in_i.target_x;
            ty_q   <= in_i.target_y;
            btn_q  <= in_i.button_bits;
            pres_q <= in_i.pen_pressure;
            if (in_i.button_bits == '0) begin
              if (hold_q != '0) begin
                hold_q <= hold_q - 2'd1;
              end else begin
                pos_x_q <= in_i.target_x;
                pos_y_q <= in_i.target_y;
                vel_x_q <= '0;
                vel_y_q <= '0;
              end
            end else begin
              hold_q <= RELEASE_TICKS;
            end
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          dx_q    <= 33'(tx_q) - 33'(pos_x_q);
          dy_q    <= 33'(ty_q) - 33'(pos_y_q);
          state_q <= S_GEG;
        end
        S_GEG: begin
          ge_q    <= 28'($signed({4'd0, grav_q})) + 28'(tz_shift(prod_q, 16));
          sh_q    <= halve;
          state_q <= S_KG1;
        end
        S_KG1: begin
          acc_q   <= prod_q[63:0];
          state_q <= S_MAGB;
        end
        S_MAGB: begin
          kg_q    <= 28'(tz_shift(prod_q, 24));
          state_q <= S_SUMD;
        end
        S_SUMD, S_SUMV: begin
          rad_q   <= acc_q + prod_q[63:0];
          root_q  <= '0;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= (state_q == S_SUMD) ? S_SQD : S_SQV;
        end
        S_SQD, S_SQS, S_SQV: begin
          rad_q  <= {rad_q[61:0], 2'b00};
          rem_q  <= sq_ge ? 35'(sq_rem_t - sq_trial) : sq_rem_t[34:0];
          root_q <= {root_q[30:0], sq_ge};
          cnt_q  <= cnt_q + 6'd1;
          if (cnt_q == SqrtLast) begin
            case (state_q)
              S_SQD:   state_q <= S_SLOAD;
              S_SQS:   state_q <= S_MULX;
              default: state_q <= S_FCHK;
            endcase
          end
        end
        S_SLOAD: begin
          rad_q   <= {15'd0, root_sh, 16'd0};
          root_q  <= '0;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_SQS;
        end
        S_MULX: begin
          s_q     <= root_q[24:0];
          state_q <= (root_q == '0) ? S_VMA : S_DLX;
        end
        S_DLX, S_DLY: begin
          num_q   <= prod_abs[59:0];
          neg_q   <= prod_q[65];
          drem_q  <= '0;
          cnt_q   <= '0;
          state_q <= (state_q == S_DLX) ? S_DIVX : S_DIVY;
        end
        S_DIVX, S_DIVY: begin
          drem_q <= dv_ge ? 25'(dv_rem_t - {1'b0, s_q}) : dv_rem_t[24:0];
          num_q  <= {num_q[58:0], dv_ge};
          cnt_q  <= cnt_q + 6'd1;
          if (cnt_q == DivLast) begin
            state_q <= (state_q == S_DIVX) ? S_ADDX : S_ADDY;
          end
        end
        S_ADDX: begin
          vel_x_q <= sat32(66'(vel_x_q) + q_s);
          state_q <= S_MULY;
        end
        S_MULY: begin
          state_q <= S_DLY;
        end
        S_ADDY: begin
          vel_y_q <= sat32(66'(vel_y_q) + q_s);
          state_q <= S_VMA;
        end
        S_VMA: begin
          sh_q    <= halve;
          state_q <= S_VMB;
        end
        S_VMB: begin
          acc_q   <= prod_q[63:0];
          state_q <= S_SUMV;
        end
        S_FCHK: begin
          if ({root_sh, 8'd0} > {17'd0, dt_q}) begin
            state_q <= S_PF;
          end else begin
            vel_x_q <= '0;
            vel_y_q <= '0;
            state_q <= S_MX;
          end
        end
        S_PF: begin
          state_q <= S_GEF;
        end
        S_GEF: begin
          ge_q    <= 28'($signed({4'd0, fric_q})) + 28'(tz_shift(prod_q, 16));
          state_q <= S_KF1;
        end
        S_KF1: begin
          state_q <= S_KF2;
        end
        S_KF2: begin
          kg_q    <= 28'(tz_shift(prod_q, 24));
          state_q <= S_FX;
        end
        S_FX: begin
          state_q <= S_FY;
        end
        S_FY: begin
          vel_x_q <= sat32(66'(vel_x_q) - tz_shift(prod_q, 16));
          state_q <= S_FYW;
        end
        S_FYW: begin
          vel_y_q <= sat32(66'(vel_y_q) - tz_shift(prod_q, 16));
          state_q <= S_MX;
        end
        S_MX: begin
          state_q <= S_MY;
        end
        S_MY: begin
          pos_x_q <= sat32(66'(pos_x_q) + tz_shift(prod_q, 24));
          state_q <= S_MYW;
        end
        S_MYW: begin
          pos_y_q <= sat32(66'(pos_y_q) + tz_shift(prod_q, 24));
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            ox_q        <= pos_x_q;
            oy_q        <= pos_y_q;
            obtn_q      <= btn_q;
            opres_q     <= pres_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // no second item is taken right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("item accepted while busy");

  // the divider only runs with a nonzero root
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DLX || state_q == S_DLY) |-> (s_q != '0))
    else $error("division by zero root");

  // release hold never exceeds its load value
  a_hold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q <= RELEASE_TICKS)
    else $error("release hold out of range");

endmodule
